@@ hdl/ffba_pkg.sv @@
// Shared types, constants and helper functions for the first-fit bitmap allocator.
// Used by every module of the block; depends on nothing else.
package ffba_pkg;

  localparam int FFBA_UNITS      = 1024;
  localparam int FFBA_WORD_W     = 32;
  localparam int FFBA_WORD_BITS  = 5;
  localparam int FFBA_SIZE_W     = 11;
  localparam int FFBA_ADDR_W     = 10;
  localparam int FFBA_START_W    = 10;
  localparam int FFBA_SUM_W      = 12;
  localparam int FFBA_IN_DATA_W  = 24;
  localparam int FFBA_OUT_DATA_W = 16;

  localparam logic FFBA_MODE_ALLOC = 1'b0;
  localparam logic FFBA_MODE_FREE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_en;
    logic scan_start;
    logic scan_en;
    logic upd_start;
    logic upd_en;
    logic res_load;
  } ffba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic alloc_bad;
    logic upd_empty;
    logic scan_hit;
    logic scan_miss;
    logic upd_done;
  } ffba_stat_t;

  // Index of the lowest set bit of a word; zero when the word is zero.
  function automatic logic [FFBA_WORD_BITS-1:0] ffba_low_index(
    input logic [FFBA_WORD_W-1:0] v
  );
    logic [FFBA_WORD_W-1:0]    iso;
    logic [FFBA_WORD_BITS-1:0] idx;
    iso = v & (~v + 1'b1);
    idx = '0;
    for (int j = 0; j < FFBA_WORD_W; j++) begin
      if (iso[j]) begin
        idx = idx | FFBA_WORD_BITS'(j);
      end
    end
    return idx;
  endfunction

endpackage

@@ hdl/ffba_ctrl.sv @@
// Controller state machine of the first-fit bitmap allocator.
// Depends on ffba_pkg for the command and status structs.
module ffba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ffba_pkg::ffba_cmd_t  cmd,
  input  ffba_pkg::ffba_stat_t stat
);
  import ffba_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_DECIDE   = 7'b0000100,
    ST_SCAN     = 7'b0001000,
    ST_UPD_INIT = 7'b0010000,
    ST_UPD      = 7'b0100000,
    ST_RESULT   = 7'b1000000
  } ffba_state_t;

  ffba_state_t state_r, state_nxt;
  logic        out_tvalid_r, out_tvalid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.clr_en = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (stat.is_free) begin
          state_nxt = stat.upd_empty ? ST_RESULT : ST_UPD_INIT;
        end else if (stat.alloc_bad) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        priority if (stat.scan_hit) begin
          state_nxt = ST_UPD_INIT;
        end else if (stat.scan_miss) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_UPD_INIT: begin
        cmd.upd_start = 1'b1;
        state_nxt     = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd_en = 1'b1;
        if (stat.upd_done) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        // The output register takes the result once it is empty or being drained.
        if (!out_tvalid_r || out_tready) begin
          cmd.res_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

@@ hdl/ffba_dp.sv @@
// Datapath of the first-fit bitmap allocator: bitmap memory, word scan pipeline,
// read-modify-write update sweep and result register. Depends on ffba_pkg.
module ffba_dp #(
  parameter int UNITS = ffba_pkg::FFBA_UNITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [ffba_pkg::FFBA_IN_DATA_W-1:0]  in_tdata,
  input  logic                                 in_tuser,
  input  ffba_pkg::ffba_cmd_t                  cmd,
  output ffba_pkg::ffba_stat_t                 stat,
  output logic [ffba_pkg::FFBA_OUT_DATA_W-1:0] out_tdata,
  output logic                                 out_tuser
);
  import ffba_pkg::*;

  localparam int W      = FFBA_WORD_W;
  localparam int WB     = FFBA_WORD_BITS;
  localparam int LW     = WB + 1;
  localparam int NW     = (UNITS + W - 1) / W;
  localparam int AW     = (NW > 1) ? $clog2(NW) : 1;
  localparam int NC     = $clog2(NW + 1);
  localparam int UW     = $clog2(UNITS + 1);
  localparam int CW     = (UW > FFBA_SUM_W) ? UW : FFBA_SUM_W;
  localparam int PAD_LO = UNITS - (NW - 1) * W;

  localparam logic [W-1:0]  PAD_MASK  = {W{1'b1}} << PAD_LO;
  localparam logic [CW-1:0] UNITS_C   = CW'(UNITS);
  localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

  // Bitmap memory, one word of W units per entry.
  logic [W-1:0]  mem [NW];
  logic [W-1:0]  rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [W-1:0]  mem_wdata;

  // Request registers.
  logic          mode_r;
  logic [CW-1:0] len_r, lo_r, hi_r, start_r;
  logic          ok_r;
  logic [W-1:0]  therm_r;
  logic          small_r;

  logic [FFBA_SIZE_W-1:0] size_in;
  logic [FFBA_ADDR_W-1:0] addr_in;
  logic [CW-1:0]          sum_in;

  // Scan pipeline.
  logic [NC-1:0] rd_ptr_r;
  logic          v1_r, v2_r;
  logic [AW-1:0] idx1_r, idx2_r;
  logic          inhit2_r, allfree2_r;
  logic [WB-1:0] inpos2_r;
  logic [LW-1:0] low2_r, high2_r;
  logic [CW-1:0] carry_r, rstart_r;

  logic [W-1:0]  used1, rev1, win1;
  logic          inhit1, issue_s;
  logic [WB-1:0] inpos1;
  logic [LW-1:0] low1, high1;

  logic [CW-1:0] base2, hit_start;
  logic [CW:0]   run_sum;
  logic          cross2, hit2, miss2;

  // Update sweep.
  logic [NC-1:0] up_ptr_r;
  logic [AW-1:0] last_r, uidx_r, lo_word;
  logic          uv_r, issue_u, first_u, last_u;
  logic [CW-1:0] hm1;
  logic [WB-1:0] lo_bit, hi_bit;
  logic [W-1:0]  umask, wdata_u;

  logic [NC-1:0] clr_cnt_r;
  logic [FFBA_START_W-1:0] out_start_r;
  logic                    out_ok_r;

  assign size_in = in_tdata[FFBA_SIZE_W-1:0];
  assign addr_in = in_tdata[FFBA_SIZE_W +: FFBA_ADDR_W];
  assign sum_in  = CW'(addr_in) + CW'(size_in);

  // ---------------- memory ----------------
  assign mem_we    = cmd.clr_en || (cmd.upd_en && uv_r);
  assign mem_waddr = cmd.clr_en ? clr_cnt_r[AW-1:0] : uidx_r;
  assign mem_wdata = cmd.clr_en ? '0 : wdata_u;
  assign mem_raddr = cmd.upd_en ? up_ptr_r[AW-1:0] : rd_ptr_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // ---------------- scan, stage 1: word analysis ----------------
  // Units past the end of the map read as used so no run can reach them.
  assign used1 = rdata_r | ((idx1_r == LAST_WORD) ? PAD_MASK : '0);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      win1[i] = &((~used1 >> i) | ~therm_r);
      rev1[i] = used1[W-1-i];
    end
  end

  assign inhit1 = small_r && (|win1);
  assign inpos1 = ffba_low_index(win1);
  assign low1   = (used1 == '0) ? LW'(W) : LW'(ffba_low_index(used1));
  assign high1  = (used1 == '0) ? LW'(W) : LW'(ffba_low_index(rev1));
  assign issue_s = cmd.scan_en && (rd_ptr_r < NC'(NW));

  // ---------------- scan, stage 2: run tracking ----------------
  assign base2     = CW'({idx2_r, WB'(0)});
  assign run_sum   = {1'b0, carry_r} + (CW + 1)'(low2_r);
  assign cross2    = run_sum >= {1'b0, len_r};
  assign hit2      = cmd.scan_en && v2_r && (cross2 || inhit2_r);
  assign miss2     = cmd.scan_en && v2_r && !hit2 && (idx2_r == LAST_WORD);
  assign hit_start = cross2 ? rstart_r : (base2 + CW'(inpos2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (cmd.scan_start) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue_s;
      v2_r <= cmd.scan_en && v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_ptr_r <= '0;
      carry_r  <= '0;
      rstart_r <= '0;
    end else begin
      if (issue_s) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (cmd.scan_en && v2_r && !hit2) begin
        if (allfree2_r) begin
          carry_r <= carry_r + CW'(W);
          if (carry_r == '0) begin
            rstart_r <= base2;
          end
        end else begin
          carry_r  <= CW'(high2_r);
          rstart_r <= base2 + CW'(W) - CW'(high2_r);
        end
      end
    end
    idx1_r     <= rd_ptr_r[AW-1:0];
    idx2_r     <= idx1_r;
    inhit2_r   <= inhit1;
    inpos2_r   <= inpos1;
    low2_r     <= low1;
    high2_r    <= high1;
    allfree2_r <= (used1 == '0);
  end

  // ---------------- update sweep ----------------
  assign issue_u = cmd.upd_en && (up_ptr_r <= NC'(last_r));
  assign lo_word = AW'(lo_r >> WB);
  assign hm1     = hi_r - 1'b1;
  assign first_u = (uidx_r == lo_word);
  assign last_u  = (uidx_r == last_r);
  assign lo_bit  = first_u ? lo_r[WB-1:0] : '0;
  assign hi_bit  = last_u ? hm1[WB-1:0] : WB'(W - 1);

  always_comb begin
    for (int j = 0; j < W; j++) begin
      umask[j] = (WB'(j) >= lo_bit) && (WB'(j) <= hi_bit);
    end
  end

  assign wdata_u = (mode_r == FFBA_MODE_ALLOC) ? (rdata_r | umask) : (rdata_r & ~umask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_r <= 1'b0;
    end else if (cmd.upd_start) begin
      uv_r <= 1'b0;
    end else begin
      uv_r <= issue_u;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_start) begin
      up_ptr_r <= NC'(lo_r >> WB);
      last_r   <= AW'(hm1 >> WB);
    end else if (issue_u) begin
      up_ptr_r <= up_ptr_r + 1'b1;
    end
    uidx_r <= up_ptr_r[AW-1:0];
  end

  // ---------------- request and result registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_tuser;
      len_r   <= CW'(size_in);
      lo_r    <= CW'(addr_in);
      hi_r    <= (sum_in > UNITS_C) ? UNITS_C : sum_in;
      ok_r    <= (in_tuser == FFBA_MODE_FREE) && (CW'(addr_in) < UNITS_C)
                 && (sum_in <= UNITS_C);
      start_r <= '0;
      small_r <= CW'(size_in) <= CW'(W);
      for (int j = 0; j < W; j++) begin
        therm_r[j] <= CW'(j) < CW'(size_in);
      end
    end else if (hit2) begin
      lo_r    <= hit_start;
      hi_r    <= hit_start + len_r;
      start_r <= hit_start;
      ok_r    <= 1'b1;
    end
    if (cmd.res_load) begin
      out_start_r <= start_r[FFBA_START_W-1:0];
      out_ok_r    <= ok_r;
    end
  end

  assign out_tdata = FFBA_OUT_DATA_W'(out_start_r);
  assign out_tuser = out_ok_r;

  always_comb begin
    stat           = '0;
    stat.clr_done  = (clr_cnt_r == NC'(NW));
    stat.is_free   = (mode_r == FFBA_MODE_FREE);
    stat.alloc_bad = (len_r == '0) || (len_r > UNITS_C);
    stat.upd_empty = (lo_r >= hi_r);
    stat.scan_hit  = hit2;
    stat.scan_miss = miss2;
    stat.upd_done  = cmd.upd_en && uv_r && last_u;
  end

endmodule

@@ hdl/first_fit_bitmap_allocator_core.sv @@
// Top level of the first-fit bitmap allocator: stream ports, controller and datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
// The block keeps one used bit for each of UNITS memory units, held 32 units to a word
// in an internal memory of ceil(UNITS/32) words. After reset a clearing pass writes every
// word to zero, one word per cycle, and the block takes no request until the pass is done.
// An allocate request scans the words in order, one word per cycle through a pipeline of
// memory read, word analysis and run tracking, and stops at the first run of free units
// that is long enough; the run is then marked used by a read-modify-write sweep over the
// words it covers, one word per cycle. A search that finds no run ends after the last
// word, and an allocate whose size is zero or larger than the map is answered without a
// scan. A free request skips the scan, and also the sweep when no part of its range lies
// inside the map. A result that finds the output register still full waits until that
// register is drained. One request is in work at a time; the result sits in an output
// register, so the next request can be taken in the same cycle that the result appears,
// while that result still waits.
// Each request yields exactly one result: start_res is the start unit of the allocated
// run (low 10 bits), zero on failure and for every free; ok is clear when no run fits,
// when the size is zero or too large, or when a free range runs past the last unit,
// in which case the part inside the map is still freed.
module first_fit_bitmap_allocator_core #(
  parameter int UNITS = ffba_pkg::FFBA_UNITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request channel.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ffba_pkg::FFBA_IN_DATA_W-1:0]  in_tdata,  // [10:0] size, [20:11] address, rest zero
  input  logic                                 in_tuser,  // [0] mode: 0 allocate, 1 free
  // Result channel.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [ffba_pkg::FFBA_OUT_DATA_W-1:0] out_tdata, // [9:0] start_res, rest zero
  output logic                                 out_tuser  // [0] ok
);
  import ffba_pkg::*;

  ffba_cmd_t  cmd;
  ffba_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  ffba_dp #(
    .UNITS (UNITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

@@ hdl/ffba_checker.sv @@
// Port-level checks for the first-fit bitmap allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_bitmap_allocator_core.
module ffba_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic [ffba_pkg::FFBA_IN_DATA_W-1:0]  in_tdata,
  input logic                                 in_tuser,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [ffba_pkg::FFBA_OUT_DATA_W-1:0] out_tdata,
  input logic                                 out_tuser
);
  import ffba_pkg::*;

  // Reset starts the clearing pass, so no request is taken and no result shows.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid high right after reset");

  // Only one request is in work: an accepted request closes the request channel.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request channel still open after a request was taken");

  // Failed requests always report a zero start unit; the check does not look at successful frees.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[FFBA_START_W-1:0] == '0)
    else $error("failed request reports a nonzero start");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or was dropped");

endmodule

bind first_fit_bitmap_allocator_core ffba_checker u_ffba_checker (.*);
